@@ rtl/core/afdc_pkg.sv @@
// shared types, field sizes and digit helpers for the ascii frame deframer
// no dependencies; used by afdc_parser and ascii_frame_deframer_checksum
package afdc_pkg;

    // digit counts of the numeric header and trailer fields
    localparam int unsigned TYPE_DIGITS = 1;
    localparam int unsigned ID_DIGITS   = 5;
    localparam int unsigned SIZE_DIGITS = 3;
    localparam int unsigned HASH_DIGITS = 3;

    // field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned TYPE_W  = 3;
    localparam int unsigned IDENT_W = 17;
    localparam int unsigned LEN_W   = 10;
    localparam int unsigned HASH_W  = 10;
    localparam int unsigned CNT_W   = 10;
    localparam int unsigned DIGIT_W = 4;

    // checksum modulus, sized for the one-step add and reduce
    localparam logic [HASH_W:0] HASH_MOD = 11'd666;

    // ascii digit range
    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

    // lowest and highest known frame type
    localparam logic [DIGIT_W-1:0] TYPE_MIN = 4'd1;
    localparam logic [DIGIT_W-1:0] TYPE_MAX = 4'd6;
    localparam logic [TYPE_W-1:0]  TYPE_UNKNOWN = 3'd0;

    // packed result beat width, rounded up to whole bytes
    localparam int unsigned RES_BITS = BYTE_W + TYPE_W + IDENT_W + LEN_W + 2 * HASH_W + 2;
    localparam int unsigned RES_W    = ((RES_BITS + 7) / 8) * 8;
    localparam int unsigned RES_PAD  = RES_W - RES_BITS;

    // frame walk
    typedef enum logic [6:0] {
        PH_IDLE = 7'b0000001,
        PH_TYPE = 7'b0000010,
        PH_ID   = 7'b0000100,
        PH_LEN  = 7'b0001000,
        PH_DATA = 7'b0010000,
        PH_HASH = 7'b0100000,
        PH_PAD  = 7'b1000000
    } t_phase;

    // one result beat
    typedef struct packed {
        logic                is_summary;
        logic [BYTE_W-1:0]   payload_byte;
        logic [TYPE_W-1:0]   msg_type;
        logic [IDENT_W-1:0]  msg_ident;
        logic [LEN_W-1:0]    payload_len;
        logic [HASH_W-1:0]   received_hash;
        logic [HASH_W-1:0]   computed_hash;
        logic                hash_ok;
        logic                format_error;
    } t_result;

    // true for an ascii decimal digit
    function automatic logic is_digit(input logic [BYTE_W-1:0] b);
        return (b >= ASCII_ZERO) && (b <= ASCII_NINE);
    endfunction

    // digit value, zero for a non-digit
    function automatic logic [DIGIT_W-1:0] digit_val(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] diff;
        diff = b - ASCII_ZERO;
        return is_digit(b) ? diff[DIGIT_W-1:0] : '0;
    endfunction

endpackage

@@ rtl/core/ascii_frame_deframer_checksum.sv @@
// ascii frame deframer with mod-666 checksum: input register, parser, result register
// an accepted beat goes into the input register, its result beat then into the result register
// throughput: one beat per cycle unless m_axis_tready stalls; each yields zero or one result beat
// the input register and result register both take a new beat in the cycle the old one leaves
// reset: synchronous active-low i_rst_n empties both registers and returns the parser to idle
module ascii_frame_deframer_checksum (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [afdc_pkg::BYTE_W-1:0]  s_axis_tdata,   // data_byte
    input  logic                         s_axis_tuser,   // frame_start
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // payload_byte, msg_type, msg_ident, payload_len, received_hash,
    // computed_hash, hash_ok, format_error, zero fill
    output logic [afdc_pkg::RES_W-1:0]   m_axis_tdata,
    output logic                         m_axis_tuser    // is_summary
);

    logic                         r_in_valid;
    logic [afdc_pkg::BYTE_W-1:0]  r_in_byte;
    logic                         r_in_start;
    logic                         r_out_valid;
    afdc_pkg::t_result            r_out;
    logic                         out_open;
    logic                         step;
    logic                         in_beat;
    logic                         res_valid;
    afdc_pkg::t_result            res;

    // handshake: the input register moves whenever the result register can load
    assign out_open      = ~r_out_valid | m_axis_tready;
    assign step          = r_in_valid & out_open;
    assign s_axis_tready = ~r_in_valid | out_open;
    assign in_beat       = s_axis_tvalid & s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_beat) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser;
        end
    end

    afdc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_start     (r_in_start),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_open) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_open && res_valid) begin
            r_out <= res;
        end
    end

    // output beat packing
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.is_summary;
    assign m_axis_tdata  = {{afdc_pkg::RES_PAD{1'b0}},
                            r_out.format_error,
                            r_out.hash_ok,
                            r_out.computed_hash,
                            r_out.received_hash,
                            r_out.payload_len,
                            r_out.msg_ident,
                            r_out.msg_type,
                            r_out.payload_byte};

endmodule

@@ rtl/core/afdc_parser.sv @@
// frame parser: phase tracking, decimal field decode and mod-666 byte sum
// depends on afdc_pkg; one byte is consumed per i_step
module afdc_parser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [afdc_pkg::BYTE_W-1:0]  i_byte,
    input  logic                         i_start,
    output logic                         o_res_valid,
    output afdc_pkg::t_result            o_res
);

    afdc_pkg::t_phase                    r_phase, n_phase, eff_phase;
    logic [afdc_pkg::CNT_W-1:0]          r_count, n_count, cnt_b, cnt_inc;
    logic [afdc_pkg::TYPE_W-1:0]         r_type, n_type, type_b;
    logic [afdc_pkg::IDENT_W-1:0]        r_ident, n_ident, ident_b;
    logic [afdc_pkg::LEN_W-1:0]          r_len, n_len, len_b;
    logic [afdc_pkg::HASH_W-1:0]         r_run, n_run, run_b;
    logic [afdc_pkg::HASH_W-1:0]         r_hfield, n_hfield, hfield_b;
    logic                                r_err, n_err, err_b;
    logic                                dig_ok;
    logic [afdc_pkg::DIGIT_W-1:0]        dig;
    logic [afdc_pkg::HASH_W:0]           run_sum;
    logic                                res_hit;
    afdc_pkg::t_result                   res;

    // frame start clears the frame context before the byte is used
    always_comb begin
        eff_phase = i_start ? afdc_pkg::PH_TYPE : r_phase;
        cnt_b     = i_start ? '0 : r_count;
        type_b    = i_start ? '0 : r_type;
        ident_b   = i_start ? '0 : r_ident;
        len_b     = i_start ? '0 : r_len;
        run_b     = i_start ? '0 : r_run;
        hfield_b  = i_start ? '0 : r_hfield;
        err_b     = i_start ? 1'b0 : r_err;
        dig_ok    = afdc_pkg::is_digit(i_byte);
        dig       = afdc_pkg::digit_val(i_byte);
        cnt_inc   = cnt_b + 10'd1;
        run_sum   = {1'b0, run_b} + {3'b000, i_byte};
        if (run_sum >= afdc_pkg::HASH_MOD) begin
            run_sum = run_sum - afdc_pkg::HASH_MOD;
        end
    end

    // next state and result for one byte
    always_comb begin
        n_phase  = eff_phase;
        n_count  = cnt_b;
        n_type   = type_b;
        n_ident  = ident_b;
        n_len    = len_b;
        n_run    = run_b;
        n_hfield = hfield_b;
        n_err    = err_b;
        res      = '0;
        res_hit  = 1'b0;
        case (eff_phase)
            afdc_pkg::PH_TYPE: begin
                n_err  = err_b | ~dig_ok;
                n_type = (dig >= afdc_pkg::TYPE_MIN && dig <= afdc_pkg::TYPE_MAX)
                       ? dig[afdc_pkg::TYPE_W-1:0] : afdc_pkg::TYPE_UNKNOWN;
                if (cnt_inc >= afdc_pkg::TYPE_DIGITS) begin
                    n_count = '0;
                    n_phase = afdc_pkg::PH_ID;
                end else begin
                    n_count = cnt_inc;
                end
            end
            afdc_pkg::PH_ID: begin
                n_err   = err_b | ~dig_ok;
                n_ident = (ident_b << 3) + (ident_b << 1)
                        + {{(afdc_pkg::IDENT_W-afdc_pkg::DIGIT_W){1'b0}}, dig};
                if (cnt_inc >= afdc_pkg::ID_DIGITS) begin
                    n_count = '0;
                    n_phase = afdc_pkg::PH_LEN;
                end else begin
                    n_count = cnt_inc;
                end
            end
            afdc_pkg::PH_LEN: begin
                n_err = err_b | ~dig_ok;
                n_len = (len_b << 3) + (len_b << 1)
                      + {{(afdc_pkg::LEN_W-afdc_pkg::DIGIT_W){1'b0}}, dig};
                if (cnt_inc >= afdc_pkg::SIZE_DIGITS) begin
                    n_count = '0;
                    n_phase = (n_len == '0) ? afdc_pkg::PH_HASH : afdc_pkg::PH_DATA;
                end else begin
                    n_count = cnt_inc;
                end
            end
            afdc_pkg::PH_DATA: begin
                n_run = run_sum[afdc_pkg::HASH_W-1:0];
                if (cnt_inc >= len_b) begin
                    n_count = '0;
                    n_phase = afdc_pkg::PH_HASH;
                end else begin
                    n_count = cnt_inc;
                end
                res_hit          = 1'b1;
                res.payload_byte = i_byte;
            end
            afdc_pkg::PH_HASH: begin
                n_err    = err_b | ~dig_ok;
                n_hfield = (hfield_b << 3) + (hfield_b << 1)
                         + {{(afdc_pkg::HASH_W-afdc_pkg::DIGIT_W){1'b0}}, dig};
                if (cnt_inc >= afdc_pkg::HASH_DIGITS) begin
                    n_count           = '0;
                    n_phase           = afdc_pkg::PH_PAD;
                    res_hit           = 1'b1;
                    res.is_summary    = 1'b1;
                    res.msg_type      = type_b;
                    res.msg_ident     = ident_b;
                    res.payload_len   = len_b;
                    res.received_hash = n_hfield;
                    res.computed_hash = run_b;
                    res.hash_ok       = (n_hfield == run_b);
                    res.format_error  = n_err;
                end else begin
                    n_count = cnt_inc;
                end
            end
            default: begin
                // idle or padding: byte is dropped
            end
        endcase
    end

    assign o_res_valid = i_step & res_hit;
    assign o_res       = res;

    // frame context registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= afdc_pkg::PH_IDLE;
            r_count  <= '0;
            r_type   <= '0;
            r_ident  <= '0;
            r_len    <= '0;
            r_run    <= '0;
            r_hfield <= '0;
            r_err    <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_type   <= n_type;
            r_ident  <= n_ident;
            r_len    <= n_len;
            r_run    <= n_run;
            r_hfield <= n_hfield;
            r_err    <= n_err;
        end
    end

    // running sum stays reduced
    a_run_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_run} < afdc_pkg::HASH_MOD)
        else $error("running checksum out of range");

    // payload count never reaches the length while in the payload
    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == afdc_pkg::PH_DATA) |-> (r_count < r_len))
        else $error("payload count passed frame length");

    // a payload beat only comes from the payload phase of the current frame
    a_payload_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.is_summary) |-> (r_phase == afdc_pkg::PH_DATA && !i_start))
        else $error("payload beat outside payload phase");

    // a summary closes the frame
    a_summary_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.is_summary) |=> (r_phase == afdc_pkg::PH_PAD))
        else $error("summary did not close the frame");

endmodule
